@@ hdl/encoder_window_speed_meter_macros.svh @@
// Assertion macros used by the checker file of the encoder window speed meter.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ENCODER_WINDOW_SPEED_METER_MACROS_SVH
`define ENCODER_WINDOW_SPEED_METER_MACROS_SVH

// Checked only outside reset.
`define EWSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define EWSM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/ewsm_pkg.sv @@
// Package of the encoder window speed meter: widths, codes, scaling constants
// and the command and status structs between controller and datapath. No dependencies.
package ewsm_pkg;

  localparam int TOTAL_WIDTH = 32;
  localparam int CMD_W       = 2;
  localparam int WIN_W       = 10;
  localparam int PPR_W       = 16;
  localparam int CNT_W       = 10;
  localparam int PULSE_W     = 9;
  localparam int RATE_W      = 10;
  localparam int RPM_W       = 16;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 8;
  localparam int M_FIELDS_W  = TOTAL_WIDTH + PULSE_W + RATE_W + RPM_W;
  localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int DIV_N_W     = 20;
  localparam int DIV_D_W     = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_N_W);

  localparam int RATE_SCALE  = 1000;
  localparam int RPM_SCALE   = 60;

  localparam logic [WIN_W-1:0] MAX_WINDOW    = WIN_W'(1000);
  localparam logic [WIN_W-1:0] MIN_WINDOW    = WIN_W'(1);
  localparam logic [WIN_W-1:0] WINDOW_RESET  = WIN_W'(100);
  localparam logic [PPR_W-1:0] PPR_RESET     = '0;
  localparam logic [PULSE_W-1:0] PULSE_SAT   = '1;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TICKS   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PULSES_PER_REV = 1'b1;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic div_rpm;
    logic load_rate;
    logic load_rpm;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic window_closed;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/ewsm_div.sv @@
// Restoring divider of the encoder window speed meter, one quotient bit per cycle.
// Depends on ewsm_pkg.
module ewsm_div import ewsm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] dividend,
  input  logic [DIV_D_W-1:0] divisor,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_N_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [DIV_N_W-1:0]   quo;
  logic [DIV_D_W:0]     rem;
  logic [DIV_D_W-1:0]   dsr;
  logic [DIV_D_W:0]     rem_shift;
  logic [DIV_D_W:0]     rem_sub;
  logic                 fits;

  assign rem_shift = {rem[DIV_D_W-1:0], quo[DIV_N_W-1]};
  assign fits      = rem_shift >= {1'b0, dsr};
  assign rem_sub   = rem_shift - {1'b0, dsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= busy && (step_cnt == LAST_STEP);
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + DIV_CNT_W'(1);
        if (step_cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub : rem_shift;
      quo <= {quo[DIV_N_W-2:0], fits};
    end
  end

endmodule

@@ hdl/ewsm_datapath.sv @@
// Datapath of the encoder window speed meter: configuration, edge and window
// counters, rate and rpm registers, divider operand selection and output register.
// Depends on ewsm_pkg and ewsm_div.
module ewsm_datapath import ewsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [CMD_W-1:0]      in_command,
  input  logic                  in_level,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tlast
);

  logic [WIN_W-1:0]       window_ticks;
  logic [PPR_W-1:0]       pulses_per_rev;
  logic [CMD_W-1:0]       cmd_q;
  logic                   level_q;
  logic                   prev_level;
  logic [TOTAL_WIDTH-1:0] total;
  logic [CNT_W-1:0]       rising;
  logic [CNT_W-1:0]       falling;
  logic [CNT_W-1:0]       elapsed;
  logic [RATE_W-1:0]      rate;
  logic                   window_closed;
  logic [CNT_W-1:0]       hold_max;
  logic [CNT_W-1:0]       hold_elapsed;
  logic [RPM_W-1:0]       rpm;

  logic [WIN_W-1:0]       win_eff;
  logic                   edge_seen;
  logic [CNT_W-1:0]       rising_inc;
  logic [CNT_W-1:0]       falling_inc;
  logic [CNT_W-1:0]       elapsed_inc;
  logic [CNT_W-1:0]       max_inc;
  logic                   closing;
  logic [CNT_W-1:0]       cur_max;
  logic [PULSE_W-1:0]     pulses_sat;
  logic [DIV_N_W-1:0]     rate_num;
  logic [RPM_W-1:0]       rpm_num;
  logic [DIV_N_W-1:0]     div_dividend;
  logic [DIV_D_W-1:0]     div_divisor;
  logic                   div_done;
  logic [DIV_N_W-1:0]     div_quotient;

  always_comb begin
    priority if (window_ticks == '0) begin
      win_eff = MIN_WINDOW;
    end else if (window_ticks > MAX_WINDOW) begin
      win_eff = MAX_WINDOW;
    end else begin
      win_eff = window_ticks;
    end
  end

  assign edge_seen   = level_q != prev_level;
  assign rising_inc  = rising + CNT_W'(edge_seen & level_q);
  assign falling_inc = falling + CNT_W'(edge_seen & ~level_q);
  assign elapsed_inc = elapsed + CNT_W'(1);
  assign max_inc     = (rising_inc >= falling_inc) ? rising_inc : falling_inc;
  assign closing     = elapsed_inc >= CNT_W'(win_eff);
  assign cur_max     = (rising >= falling) ? rising : falling;
  assign pulses_sat  = (cur_max > CNT_W'(PULSE_SAT)) ? PULSE_SAT : cur_max[PULSE_W-1:0];

  assign rate_num     = DIV_N_W'(hold_max) * DIV_N_W'(RATE_SCALE);
  assign rpm_num      = RPM_W'(rate) * RPM_W'(RPM_SCALE);
  assign div_dividend = cmd.div_rpm ? DIV_N_W'(rpm_num) : rate_num;
  assign div_divisor  = cmd.div_rpm ? pulses_per_rev : DIV_D_W'(hold_elapsed);

  ewsm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign status.window_closed = window_closed;
  assign status.div_done      = div_done;
  assign status.out_free      = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks   <= WINDOW_RESET;
      pulses_per_rev <= PPR_RESET;
      prev_level     <= 1'b0;
      total          <= '0;
      rising         <= '0;
      falling        <= '0;
      elapsed        <= '0;
      rate           <= '0;
      window_closed  <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_WINDOW_TICKS:   window_ticks   <= cfg_wdata[WIN_W-1:0];
          CFG_PULSES_PER_REV: pulses_per_rev <= cfg_wdata[PPR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.update) begin
        window_closed <= 1'b0;
        unique case (cmd_q)
          CMD_TICK: begin
            prev_level <= level_q;
            total      <= total + TOTAL_WIDTH'(edge_seen);
            if (closing) begin
              rising        <= '0;
              falling       <= '0;
              elapsed       <= '0;
              window_closed <= 1'b1;
            end else begin
              rising  <= rising_inc;
              falling <= falling_inc;
              elapsed <= elapsed_inc;
            end
          end
          CMD_CLEAR, CMD_INIT: begin
            total   <= '0;
            rising  <= '0;
            falling <= '0;
            elapsed <= '0;
            rate    <= '0;
            if (cmd_q == CMD_INIT) begin
              prev_level <= level_q;
            end
          end
          default: ;
        endcase
      end
      if (cmd.load_rate) begin
        rate <= div_quotient[RATE_W-1:0];
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q   <= in_command;
      level_q <= in_level;
    end
    if (cmd.update) begin
      hold_max     <= max_inc;
      hold_elapsed <= elapsed_inc;
    end
    if (cmd.load_rpm) begin
      rpm <= (pulses_per_rev == '0) ? '0 : div_quotient[RPM_W-1:0];
    end
    if (cmd.emit) begin
      m_tdata <= {(M_TDATA_W - M_FIELDS_W)'(0), rpm, rate, pulses_sat, total};
      m_tlast <= window_closed;
    end
  end

endmodule

@@ hdl/ewsm_ctrl.sv @@
// Controller of the encoder window speed meter: sequences capture, count update,
// the rate division when a window closes, the rpm division and the output load. Depends on ewsm_pkg.
module ewsm_ctrl import ewsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_UPDATE    = 7'b0000010,
    S_RATE_GO   = 7'b0000100,
    S_RATE_WAIT = 7'b0001000,
    S_RPM_GO    = 7'b0010000,
    S_RPM_WAIT  = 7'b0100000,
    S_EMIT      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_RATE_GO;
      end
      S_RATE_GO: begin
        if (status.window_closed) begin
          cmd.div_start = 1'b1;
          state_next    = S_RATE_WAIT;
        end else begin
          state_next = S_RPM_GO;
        end
      end
      S_RATE_WAIT: begin
        if (status.div_done) begin
          cmd.load_rate = 1'b1;
          state_next    = S_RPM_GO;
        end
      end
      S_RPM_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_rpm   = 1'b1;
        state_next    = S_RPM_WAIT;
      end
      S_RPM_WAIT: begin
        cmd.div_rpm = 1'b1;
        if (status.div_done) begin
          cmd.load_rpm = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/encoder_window_speed_meter.sv @@
// Top level of the encoder window speed meter: joins controller and datapath.
// Depends on ewsm_pkg, ewsm_ctrl and ewsm_datapath.
//
// Channel   Direction  Contents
// s_*       in         tuser: command; tdata: level_a in bit 0
// m_*       out        tdata: total, window pulses, pulse rate, shaft rpm; tlast: window done
// cfg_*     in         write of window_ticks (index 0) or pulses_per_rev (index 1)
//
// An item occupies the block until its result is loaded into the output register.
// The shared 20-step divider runs for rate when the item closes a window, then always for rpm.
// The next item is taken while the previous result waits in the output register.
// Reset is synchronous and clears all counters; no clearing pass is needed.
module encoder_window_speed_meter import ewsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // [0] level_a, rest zero
  input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // [31:0] total, [40:32] pulses, [50:41] rate,
                                           // [66:51] rpm, rest zero
  output logic                  m_tlast,   // window done
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ewsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ewsm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_command (s_tuser),
    .in_level   (s_tdata[0]),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

@@ hdl/ewsm_checker.sv @@
// Port-level checker of the encoder window speed meter, bound to the top level.
// Depends on ewsm_pkg and encoder_window_speed_meter_macros.svh.
`include "encoder_window_speed_meter_macros.svh"

module ewsm_checker import ewsm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_TDATA_W-1:0]  m_tdata,
  input logic                  m_tlast
);

  `EWSM_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !m_tvalid, "output valid after reset")
  `EWSM_ASSERT(a_one_item_at_a_time, s_tvalid && s_tready |=> !s_tready, "second item taken early")
  `EWSM_ASSERT(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed under stall")
  `EWSM_ASSERT(a_closed_window_empty, m_tvalid && m_tlast |-> m_tdata[40:32] == '0, "window count not cleared at window end")
  `EWSM_ASSERT(a_rate_bounded, m_tvalid |-> m_tdata[50:41] <= RATE_W'(RATE_SCALE), "pulse rate above bound")

endmodule

bind encoder_window_speed_meter ewsm_checker u_ewsm_checker (.*);
